@@ hw/rtl/bitrate_candidate_scorer_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - assertion macros
// Shared property forms used by the scorer modules that carry checks.
// ---------------------------------------------------------------------------
`ifndef BITRATE_CANDIDATE_SCORER_UNIT_DEFINES_SVH
`define BITRATE_CANDIDATE_SCORER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bcs_pkg.sv @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - package
// Item and result types, event and verdict codes, scoring weights.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

  // Event modes of an input item
  localparam logic [2:0] MODE_OPEN   = 3'd0;
  localparam logic [2:0] MODE_FRAME  = 3'd1;
  localparam logic [2:0] MODE_ALERT  = 3'd2;
  localparam logic [2:0] MODE_CLOSE  = 3'd3;
  localparam logic [2:0] MODE_FINISH = 3'd4;

  // Work kinds passed from front to back
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE      = 2'd0;
  localparam logic [1:0] VERDICT_WINNER    = 2'd1;
  localparam logic [1:0] VERDICT_NO_ACT    = 2'd2;
  localparam logic [1:0] VERDICT_NO_CLEAR  = 2'd3;

  // Scoring weights
  localparam int HIT_WEIGHT     = 100;
  localparam int SLOT_WEIGHT    = 200;
  localparam int FAULT_WEIGHT   = 5000;
  localparam int OVERRUN_WEIGHT = 2000;
  localparam int MISS_WEIGHT    = 10;

  localparam logic [15:0] MARGIN_RESET = 16'd500;
  localparam int          MASK_BITS    = 5;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO    = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [19:0] bit_rate;
    logic        frame_accepted;
    logic        slot_valid;
    logic [2:0]  slot_index;
    logic        alert_bus_off;
    logic        alert_error_passive;
    logic        alert_queue_full;
    logic [15:0] missed_count;
  } item_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic signed [31:0] window_score;
    logic [19:0]        best_rate;
    logic [19:0]        second_rate;
    logic               second_usable;
    logic [4:0]         present_mask;
  } result_t;

  // Width of one front-to-back work word
  function automatic int work_width(input int slots, input int cbits);
    return 2 + slots + 20 + 2 * cbits + (cbits + 3) + 4 + 4 * cbits;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bitrate_candidate_scorer_unit.sv @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - top level
// Scores listen windows at trial bus bit rates and reports the winner.
// ---------------------------------------------------------------------------
// Event items (open, frame, alert, close, finish) enter through a queue-like
// port and each one yields exactly one result, in order. While full is low,
// the block sustains one item per clock cycle. A push updates the front
// counters and writes the work queue; the item then passes through the
// three score stages (weighted terms, credit/penalty sums, 32-bit clamp)
// and is written to the result queue, with ranking done on the last
// stage's output as it is written; it can then be popped from there.
// Up to four work words wait between front and back and up to
// four results wait at the output; full rises only when both queues have
// filled behind a result side that is not popping. The clear_margin register
// is written through its own valid/ready channel, which is always ready, and
// should be written only while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitrate_candidate_scorer_unit
  import bcs_pkg::*;
#(
  parameter int SLOT_COUNT = 5,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire item_t       item,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int WORK_W  = work_width(SLOT_COUNT, COUNT_BITS);
  localparam int RES_W   = $bits(result_t);
  localparam int Q_DEPTH = 4;

  logic [15:0]       clear_margin;
  logic              work_wr;
  logic [WORK_W-1:0] work_in;
  logic              work_full;
  logic              work_pop;
  logic [WORK_W-1:0] work_out;
  logic              work_empty;
  logic              out_wr;
  result_t           out_data;
  logic              out_full;
  logic [RES_W-1:0]  out_rd;

  // Configuration channel: take every transfer at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_margin <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clear_margin <= cfg_data;
    end
  end

  // Input side is full only when the work queue is
  assign full = work_full;

  // Front: window counters and classification
  bcs_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_BITS (COUNT_BITS),
    .WORK_W     (WORK_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (work_full),
    .item      (item),
    .work_wr   (work_wr),
    .work_data (work_in)
  );

  // Work queue decouples front and back
  bcs_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (Q_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (work_wr),
    .wr_data (work_in),
    .full    (work_full),
    .rd_en   (work_pop),
    .rd_data (work_out),
    .empty   (work_empty)
  );

  // Back: scoring, ranking, verdict; advances whenever the result queue has room
  bcs_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_BITS (COUNT_BITS),
    .WORK_W     (WORK_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clear_margin (clear_margin),
    .work_empty   (work_empty),
    .work_data    (work_out),
    .work_pop     (work_pop),
    .out_room     (!out_full),
    .out_wr       (out_wr),
    .out_data     (out_data)
  );

  // Result queue: holds finished results until popped
  bcs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (Q_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (RES_W'(out_data)),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign result = result_t'(out_rd);

endmodule

`default_nettype wire

@@ hw/rtl/bcs_fifo.sv @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - small queue
// Register-based first-in first-out queue with occupancy count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitrate_candidate_scorer_unit_defines.svh"

module bcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `BCS_ASSERT_HOLDS(a_fifo_bound, 1'b1, count <= CW'(DEPTH), "queue count beyond depth")
  `BCS_ASSERT_NEXT(a_fifo_fill, do_wr && !do_rd, count == $past(count) + 1'b1, "fill lost")
  `BCS_ASSERT_NEXT(a_fifo_drain, do_rd && !do_wr, count == $past(count) - 1'b1, "drain lost")

endmodule

`default_nettype wire

@@ hw/rtl/bcs_front.sv @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - front end
// Takes event items, keeps the window counters and issues work words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcs_front
  import bcs_pkg::*;
#(
  parameter int SLOT_COUNT = 5,
  parameter int COUNT_BITS = 16,
  parameter int WORK_W     = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              full,
  input  wire item_t             item,
  output logic                   work_wr,
  output logic [WORK_W-1:0]      work_data
);

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int HW     = COUNT_BITS + 3;
  localparam logic [MW-1:0] CNT_MAX = MW'((64'd1 << COUNT_BITS) - 64'd1);

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_COUNT-1:0] seen;
    logic [19:0]           rate;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] expected;
    logic [HW-1:0]         hits;
    logic [3:0]            distinct;
    logic [COUNT_BITS-1:0] err_bo;
    logic [COUNT_BITS-1:0] err_ep;
    logic [COUNT_BITS-1:0] err_qf;
    logic [COUNT_BITS-1:0] missed;
  } work_t;

  logic [19:0]           rate;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] expected;
  logic [COUNT_BITS-1:0] slot_counts [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] seen;
  logic [HW-1:0]         hits;
  logic [COUNT_BITS-1:0] err_bo;
  logic [COUNT_BITS-1:0] err_ep;
  logic [COUNT_BITS-1:0] err_qf;

  logic [19:0]           rate_next;
  logic [COUNT_BITS-1:0] total_next;
  logic [COUNT_BITS-1:0] expected_next;
  logic [COUNT_BITS-1:0] slot_counts_next [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] seen_next;
  logic [HW-1:0]         hits_next;
  logic [COUNT_BITS-1:0] err_bo_next;
  logic [COUNT_BITS-1:0] err_ep_next;
  logic [COUNT_BITS-1:0] err_qf_next;

  logic                  accept;
  logic                  hit_ok;
  logic [SIDX_W-1:0]     sidx;
  logic [MW-1:0]         missed_ext;
  logic [3:0]            distinct;
  work_t                 work;

  assign accept = push && !full;
  assign sidx   = item.slot_index[SIDX_W-1:0];
  assign hit_ok = item.frame_accepted && item.slot_valid &&
                  (4'(item.slot_index) < 4'(SLOT_COUNT));

  always_comb begin
    rate_next     = rate;
    total_next    = total;
    expected_next = expected;
    seen_next     = seen;
    hits_next     = hits;
    err_bo_next   = err_bo;
    err_ep_next   = err_ep;
    err_qf_next   = err_qf;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_counts_next[i] = slot_counts[i];
    end
    unique case (item.mode)
      MODE_OPEN: begin
        rate_next     = item.bit_rate;
        total_next    = '0;
        expected_next = '0;
        seen_next     = '0;
        hits_next     = '0;
        err_bo_next   = '0;
        err_ep_next   = '0;
        err_qf_next   = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slot_counts_next[i] = '0;
        end
      end
      MODE_FRAME: begin
        if (total != '1) total_next = total + 1'b1;
        if (hit_ok) begin
          if (expected != '1) expected_next = expected + 1'b1;
          // hits follows the sum of the saturated slot counts
          if (slot_counts[sidx] != '1) begin
            slot_counts_next[sidx] = slot_counts[sidx] + 1'b1;
            hits_next              = hits + 1'b1;
          end
          seen_next[sidx] = 1'b1;
        end
      end
      MODE_ALERT: begin
        if (item.alert_bus_off && err_bo != '1)       err_bo_next = err_bo + 1'b1;
        if (item.alert_error_passive && err_ep != '1) err_ep_next = err_ep + 1'b1;
        if (item.alert_queue_full && err_qf != '1)    err_qf_next = err_qf + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A slot's mask bit is set exactly when its count is non-zero
  always_comb begin
    distinct = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      distinct = distinct + 4'(seen_next[i]);
    end
  end

  assign missed_ext = MW'(item.missed_count);

  always_comb begin
    work.seen     = seen_next;
    work.rate     = rate_next;
    work.total    = total_next;
    work.expected = expected_next;
    work.hits     = hits_next;
    work.distinct = distinct;
    work.err_bo   = err_bo_next;
    work.err_ep   = err_ep_next;
    work.err_qf   = err_qf_next;
    work.missed   = (missed_ext > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                           : missed_ext[COUNT_BITS-1:0];
    unique case (item.mode)
      MODE_CLOSE:  work.kind = KIND_CLOSE;
      MODE_FINISH: work.kind = KIND_FINISH;
      default:     work.kind = KIND_STATUS;
    endcase
  end

  assign work_wr   = accept;
  assign work_data = WORK_W'(work);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate     <= '0;
      total    <= '0;
      expected <= '0;
      seen     <= '0;
      hits     <= '0;
      err_bo   <= '0;
      err_ep   <= '0;
      err_qf   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_counts[i] <= '0;
      end
    end else if (accept) begin
      rate     <= rate_next;
      total    <= total_next;
      expected <= expected_next;
      seen     <= seen_next;
      hits     <= hits_next;
      err_bo   <= err_bo_next;
      err_ep   <= err_ep_next;
      err_qf   <= err_qf_next;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_counts[i] <= slot_counts_next[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bcs_back.sv @@
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - back end
// Score pipeline, best and second-best ranking, verdict and result build.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitrate_candidate_scorer_unit_defines.svh"

module bcs_back
  import bcs_pkg::*;
#(
  parameter int SLOT_COUNT = 5,
  parameter int COUNT_BITS = 16,
  parameter int WORK_W     = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       clear_margin,
  input  wire logic              work_empty,
  input  wire logic [WORK_W-1:0] work_data,
  output logic                   work_pop,
  input  wire logic              out_room,
  output logic                   out_wr,
  output result_t                out_data
);

  localparam int HW = COUNT_BITS + 3;
  localparam int SW = COUNT_BITS + 16;
  localparam int PMW = (SLOT_COUNT > MASK_BITS) ? SLOT_COUNT : MASK_BITS;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_COUNT-1:0] seen;
    logic [19:0]           rate;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] expected;
    logic [HW-1:0]         hits;
    logic [3:0]            distinct;
    logic [COUNT_BITS-1:0] err_bo;
    logic [COUNT_BITS-1:0] err_ep;
    logic [COUNT_BITS-1:0] err_qf;
    logic [COUNT_BITS-1:0] missed;
  } work_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_COUNT-1:0] seen;
    logic [19:0]           rate;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] expected;
  } meta_t;

  work_t              work;
  logic               en;

  logic               s1_valid;
  meta_t              s1_meta;
  logic [SW-1:0]      s1_hits;
  logic [SW-1:0]      s1_dist;
  logic [SW-1:0]      s1_fault;
  logic [SW-1:0]      s1_over;
  logic [SW-1:0]      s1_miss;

  logic               s2_valid;
  meta_t              s2_meta;
  logic [SW-1:0]      s2_pos;
  logic [SW-1:0]      s2_neg;

  logic               s3_valid;
  meta_t              s3_meta;
  logic signed [31:0] s3_score;

  logic signed [SW:0] diff;
  logic signed [63:0] diff_wide;
  logic signed [31:0] score_sat;

  logic signed [31:0]    lead_score;
  logic signed [31:0]    trail_score;
  logic [19:0]           best_rate;
  logic [COUNT_BITS-1:0] best_total;
  logic [COUNT_BITS-1:0] best_expected;
  logic [19:0]           second_rate;
  logic [COUNT_BITS-1:0] second_total;
  logic [COUNT_BITS-1:0] second_expected;

  logic signed [31:0]    lead_score_next;
  logic signed [31:0]    trail_score_next;
  logic [19:0]           best_rate_next;
  logic [COUNT_BITS-1:0] best_total_next;
  logic [COUNT_BITS-1:0] best_expected_next;
  logic [19:0]           second_rate_next;
  logic [COUNT_BITS-1:0] second_total_next;
  logic [COUNT_BITS-1:0] second_expected_next;

  logic                  is_close;
  logic                  is_finish;
  logic                  beats_best;
  logic                  take_lead;
  logic signed [33:0]    gap;
  logic [1:0]            verdict;
  logic [PMW-1:0]        mask_ext;

  assign work     = work_t'(work_data);
  assign en       = out_room;
  assign work_pop = en && !work_empty;

  // Stage 1: weighted terms
  always_ff @(posedge clk) begin
    if (en) begin
      s1_meta  <= '{kind: work.kind, seen: work.seen, rate: work.rate,
                    total: work.total, expected: work.expected};
      s1_hits  <= SW'(work.hits) * SW'(HIT_WEIGHT);
      s1_dist  <= SW'(work.distinct) * SW'(SLOT_WEIGHT);
      s1_fault <= (SW'(work.err_bo) + SW'(work.err_ep)) * SW'(FAULT_WEIGHT);
      s1_over  <= SW'(work.err_qf) * SW'(OVERRUN_WEIGHT);
      s1_miss  <= SW'(work.missed) * SW'(MISS_WEIGHT);
    end
  end

  // Stage 2: credit and penalty sums
  always_ff @(posedge clk) begin
    if (en) begin
      s2_meta <= s1_meta;
      s2_pos  <= s1_hits + s1_dist + SW'(s1_meta.total);
      s2_neg  <= s1_fault + s1_over + s1_miss;
    end
  end

  // Stage 3: difference clamped to 32-bit signed
  assign diff      = $signed({1'b0, s2_pos}) - $signed({1'b0, s2_neg});
  assign diff_wide = 64'(diff);
  assign score_sat = (diff_wide > SAT_HI) ? 32'(SAT_HI) :
                     (diff_wide < SAT_LO) ? 32'(SAT_LO) : 32'(diff_wide);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_meta  <= s2_meta;
      s3_score <= score_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= !work_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Ranking on close
  assign is_close   = (s3_meta.kind == KIND_CLOSE);
  assign is_finish  = (s3_meta.kind == KIND_FINISH);
  assign beats_best = (s3_score > lead_score);
  assign take_lead  = out_wr && is_close && beats_best;

  always_comb begin
    lead_score_next      = lead_score;
    trail_score_next     = trail_score;
    best_rate_next       = best_rate;
    best_total_next      = best_total;
    best_expected_next   = best_expected;
    second_rate_next     = second_rate;
    second_total_next    = second_total;
    second_expected_next = second_expected;
    if (s3_valid && is_close) begin
      if (beats_best) begin
        trail_score_next     = lead_score;
        second_rate_next     = best_rate;
        second_total_next    = best_total;
        second_expected_next = best_expected;
        lead_score_next      = s3_score;
        best_rate_next       = s3_meta.rate;
        best_total_next      = s3_meta.total;
        best_expected_next   = s3_meta.expected;
      end else if (s3_score > trail_score) begin
        trail_score_next     = s3_score;
        second_rate_next     = s3_meta.rate;
        second_total_next    = s3_meta.total;
        second_expected_next = s3_meta.expected;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_score      <= SCORE_MIN;
      trail_score     <= SCORE_MIN;
      best_rate       <= '0;
      best_total      <= '0;
      best_expected   <= '0;
      second_rate     <= '0;
      second_total    <= '0;
      second_expected <= '0;
    end else if (en) begin
      lead_score      <= lead_score_next;
      trail_score     <= trail_score_next;
      best_rate       <= best_rate_next;
      best_total      <= best_total_next;
      best_expected   <= best_expected_next;
      second_rate     <= second_rate_next;
      second_total    <= second_total_next;
      second_expected <= second_expected_next;
    end
  end

  // Verdict on finish; finish leaves the ranking untouched
  assign gap = 34'(lead_score) - 34'(trail_score);

  always_comb begin
    verdict = VERDICT_NONE;
    if (is_finish) begin
      if (best_total == '0 && best_expected == '0) begin
        verdict = VERDICT_NO_ACT;
      end else if (trail_score != SCORE_MIN && gap < $signed({18'd0, clear_margin})) begin
        verdict = VERDICT_NO_CLEAR;
      end else begin
        verdict = VERDICT_WINNER;
      end
    end
  end

  assign mask_ext = PMW'(s3_meta.seen);

  assign out_wr = en && s3_valid;

  always_comb begin
    out_data.verdict       = verdict;
    out_data.window_score  = is_close ? s3_score : 32'sd0;
    out_data.best_rate     = best_rate_next;
    out_data.second_rate   = second_rate_next;
    out_data.second_usable = (trail_score_next != SCORE_MIN) &&
                             (second_total_next != '0 || second_expected_next != '0);
    out_data.present_mask  = mask_ext[MASK_BITS-1:0];
  end

  `BCS_ASSERT_HOLDS(a_rank_order, 1'b1, lead_score >= trail_score, "second ranks above best")
  `BCS_ASSERT_NEXT(a_demote, take_lead, trail_score == $past(lead_score), "best not demoted")
  `BCS_ASSERT_NEXT(a_stall_hold, !en && s3_valid, s3_valid && $stable(s3_score), "score moved")

endmodule

`default_nettype wire

@@ tb/bitrate_candidate_scorer_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit-rate candidate scorer - self-checking testbench
// Drives open, frame, alert, close and finish events through the push side.
// It predicts every result with its own window scorer and checks each popped
// result against the oldest prediction. The run covers directed corner
// cases, margin register extremes and a long randomised scan. Both sides
// idle at random.
// ---------------------------------------------------------------------------

module bitrate_candidate_scorer_unit_tb;
  import bcs_pkg::*;

  localparam int          SLOTS            = 5;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int          RANDOM_ITEMS     = 1450;
  localparam int          RANDOM_PHASES    = 5;
  localparam logic [2:0]  MODE_UNUSED_LAST = 3'd7;
  localparam longint      SCORE_FLOOR      = -64'sd2147483648;
  localparam longint      SCORE_CEIL       = 64'sd2147483647;

  typedef struct {
    logic [19:0] rate;
    logic [15:0] total;
    logic [15:0] expected;
  } window_entry_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = '0;
  item_t       item      = '0;
  logic        full;
  logic        empty;
  logic        cfg_ready;
  result_t     result;

  // Scorer state as the testbench sees it
  logic [15:0]   clear_margin_model;
  logic [19:0]   window_rate;
  logic [15:0]   frames_total;
  logic [15:0]   frames_expected;
  logic [15:0]   slot_hits [SLOTS];
  logic [4:0]    slots_seen;
  logic [15:0]   fault_counts [3];
  logic [15:0]   frames_missed;
  longint        lead_score;
  longint        runner_score;
  window_entry_t best_window;
  window_entry_t runner_window;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;   // no idling on either side while set

  bitrate_candidate_scorer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_window_counts();
    frames_total    = '0;
    frames_expected = '0;
    slots_seen      = '0;
    frames_missed   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_hits[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      fault_counts[i] = '0;
    end
  endfunction

  function automatic void reset_scan_model();
    clear_margin_model = MARGIN_RESET;
    window_rate        = '0;
    clear_window_counts();
    lead_score    = SCORE_FLOOR;
    runner_score  = SCORE_FLOOR;
    best_window   = '{default: '0};
    runner_window = '{default: '0};
  endfunction

  // Work out the result of one accepted event and queue it.
  function automatic void predict_event(item_t ev);
    result_t       r;
    longint        hits;
    longint        distinct;
    longint        s;
    window_entry_t cur;
    r = '0;
    case (ev.mode)
      MODE_OPEN: begin
        window_rate = ev.bit_rate;
        clear_window_counts();
      end
      MODE_FRAME: begin
        frames_total = bump(frames_total);
        if (ev.frame_accepted && ev.slot_valid && ev.slot_index < SLOTS) begin
          frames_expected           = bump(frames_expected);
          slot_hits[ev.slot_index]  = bump(slot_hits[ev.slot_index]);
          slots_seen[ev.slot_index] = 1'b1;
        end
      end
      MODE_ALERT: begin
        if (ev.alert_bus_off)       fault_counts[0] = bump(fault_counts[0]);
        if (ev.alert_error_passive) fault_counts[1] = bump(fault_counts[1]);
        if (ev.alert_queue_full)    fault_counts[2] = bump(fault_counts[2]);
      end
      MODE_CLOSE: begin
        frames_missed = ev.missed_count;
        hits     = 0;
        distinct = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_hits[i] != 0) begin
            distinct++;
            hits += longint'(slot_hits[i]);
          end
        end
        s = hits * HIT_WEIGHT + distinct * SLOT_WEIGHT + longint'(frames_total)
            - (longint'(fault_counts[0]) + longint'(fault_counts[1])) * FAULT_WEIGHT
            - longint'(fault_counts[2]) * OVERRUN_WEIGHT
            - longint'(frames_missed) * MISS_WEIGHT;
        if (s > SCORE_CEIL)  s = SCORE_CEIL;
        if (s < SCORE_FLOOR) s = SCORE_FLOOR;
        r.window_score = s[31:0];
        cur.rate     = window_rate;
        cur.total    = frames_total;
        cur.expected = frames_expected;
        // Strict ranking: a tie never displaces the entry it ties with
        if (s > lead_score) begin
          runner_score  = lead_score;
          runner_window = best_window;
          lead_score    = s;
          best_window   = cur;
        end else if (s > runner_score) begin
          runner_score  = s;
          runner_window = cur;
        end
      end
      MODE_FINISH: begin
        if (best_window.total == 0 && best_window.expected == 0)
          r.verdict = VERDICT_NO_ACT;
        else if (runner_score != SCORE_FLOOR &&
                 (lead_score - runner_score) < longint'(clear_margin_model))
          r.verdict = VERDICT_NO_CLEAR;
        else
          r.verdict = VERDICT_WINNER;
      end
      default: ;  // spare modes only report status
    endcase
    r.best_rate     = best_window.rate;
    r.second_rate   = runner_window.rate;
    r.second_usable = (runner_score != SCORE_FLOOR) &&
                      (runner_window.total != 0 || runner_window.expected != 0);
    r.present_mask  = slots_seen;
    pending_results.push_back(r);
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random stalls, check every transfer against the oldest
  // prediction
  // ------------------------------------------------------------------------
  task automatic check_against_oldest(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result popped with no prediction waiting: %h", got);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
        mismatch_count++;
      end
      if (got.window_score !== want.window_score) begin
        $error("window_score: expected %0d, actual %0d",
               want.window_score, got.window_score);
        mismatch_count++;
      end
      if (got.best_rate !== want.best_rate) begin
        $error("best_rate: expected %0d, actual %0d", want.best_rate, got.best_rate);
        mismatch_count++;
      end
      if (got.second_rate !== want.second_rate) begin
        $error("second_rate: expected %0d, actual %0d",
               want.second_rate, got.second_rate);
        mismatch_count++;
      end
      if (got.second_usable !== want.second_usable) begin
        $error("second_usable: expected %0d, actual %0d",
               want.second_usable, got.second_usable);
        mismatch_count++;
      end
      if (got.present_mask !== want.present_mask) begin
        $error("present_mask: expected %b, actual %b",
               want.present_mask, got.present_mask);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin : result_side
    int unsigned hold;
    int unsigned low_left;
    if (rst) begin
      pop      <= 1'b0;
      low_left = 0;
    end else if (pop && !empty) begin
      check_against_oldest(result);
      hold = calm ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        pop      <= 1'b0;
        low_left = hold;
      end
    end else if (!pop) begin
      // Hold pop low for the drawn number of cycles, then raise it
      if (low_left <= 1) begin
        pop <= 1'b1;
      end
      low_left = (low_left == 0) ? 0 : low_left - 1;
    end
  end

  // ------------------------------------------------------------------------
  // Push side
  // ------------------------------------------------------------------------
  // Send one event after a random gap; push stays high across back-to-back
  // transfers so it is never lowered and raised in the same step.
  task automatic push_event(item_t ev);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= ev;
    do @(posedge clk); while (full);
    predict_event(ev);
  endtask

  // Drop push and wait for every predicted result to be popped.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_clear_margin(logic [15:0] margin);
    cfg_valid <= 1'b1;
    cfg_data  <= margin;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clear_margin_model = margin;
  endtask

  // Event builders: unused fields carry random noise, which must be ignored
  function automatic item_t noise_event();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t open_event(logic [19:0] rate);
    item_t ev;
    ev          = noise_event();
    ev.mode     = MODE_OPEN;
    ev.bit_rate = rate;
    return ev;
  endfunction

  function automatic item_t frame_event(logic acc, logic valid, logic [2:0] idx);
    item_t ev;
    ev                = noise_event();
    ev.mode           = MODE_FRAME;
    ev.frame_accepted = acc;
    ev.slot_valid     = valid;
    ev.slot_index     = idx;
    return ev;
  endfunction

  function automatic item_t alert_event(logic bus_off, logic passive, logic qfull);
    item_t ev;
    ev                     = noise_event();
    ev.mode                = MODE_ALERT;
    ev.alert_bus_off       = bus_off;
    ev.alert_error_passive = passive;
    ev.alert_queue_full    = qfull;
    return ev;
  endfunction

  function automatic item_t close_event(logic [15:0] missed);
    item_t ev;
    ev              = noise_event();
    ev.mode         = MODE_CLOSE;
    ev.missed_count = missed;
    return ev;
  endfunction

  function automatic item_t finish_event();
    item_t ev;
    ev      = noise_event();
    ev.mode = MODE_FINISH;
    return ev;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Fresh scan: no activity, spare modes, close with no window opened.
  task automatic test_reset_behaviour();
    item_t ev;
    push_event(finish_event());
    for (int m = MODE_FINISH + 1; m <= MODE_UNUSED_LAST; m++) begin
      ev      = noise_event();
      ev.mode = m[2:0];
      push_event(ev);
    end
    push_event(close_event(16'd0));
    push_event(finish_event());
  endtask

  // Every slot, out-of-range and filtered frames, alerts, ranking ties.
  task automatic test_directed_windows();
    push_event(open_event(20'hFFFFF));
    for (int i = 0; i < SLOTS; i++) begin
      push_event(frame_event(1'b1, 1'b1, i[2:0]));
    end
    push_event(frame_event(1'b1, 1'b1, 3'd5));
    push_event(frame_event(1'b1, 1'b1, 3'd7));
    push_event(frame_event(1'b0, 1'b1, 3'd0));
    push_event(frame_event(1'b1, 1'b0, 3'd3));
    push_event(alert_event(1'b1, 1'b1, 1'b1));
    push_event(alert_event(1'b0, 1'b0, 1'b0));
    push_event(close_event(16'd0));
    push_event(finish_event());
    push_event(open_event(20'h00001));
    push_event(frame_event(1'b1, 1'b1, 3'd1));
    push_event(frame_event(1'b1, 1'b1, 3'd1));
    push_event(close_event(16'd0));
    push_event(finish_event());
    // Same score again: ties the best, displaces only the second
    push_event(open_event(20'h00002));
    push_event(frame_event(1'b1, 1'b1, 3'd3));
    push_event(frame_event(1'b1, 1'b1, 3'd3));
    push_event(close_event(16'd0));
    // Re-close the same counters with the largest missed count
    push_event(close_event(16'hFFFF));
    push_event(finish_event());
  endtask

  // Margin extremes against a zero lead between best and second.
  task automatic test_clear_margin();
    logic [15:0] margins [4];
    margins = '{16'd0, 16'hFFFF, 16'($urandom), MARGIN_RESET};
    foreach (margins[i]) begin
      wait_idle();
      set_clear_margin(margins[i]);
      push_event(finish_event());
    end
  endtask

  // Mostly well-formed windows with random content, some noise, over
  // several margin settings.
  task automatic test_random_scan();
    int unsigned sent;
    int unsigned phase_target;
    int unsigned n;
    logic [15:0] missed;
    item_t       ev;
    sent = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       set_clear_margin(16'hFFFF);
        1:       set_clear_margin(16'd0);
        3:       set_clear_margin(MARGIN_RESET);
        default: set_clear_margin(16'($urandom_range(0, 3000)));
      endcase
      phase_target = RANDOM_ITEMS * (phase + 1) / RANDOM_PHASES;
      while (sent < phase_target) begin
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 8) begin
          push_event(open_event(20'($urandom)));
          n = $urandom_range(0, 12);
          repeat (n) begin
            if ($urandom_range(0, 4) != 0) begin
              ev = frame_event($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                               ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, SLOTS - 1))
                                                           : 3'($urandom_range(0, 7)));
            end else begin
              ev = alert_event($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                               $urandom_range(0, 3) == 0);
            end
            push_event(ev);
          end
          missed = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 30))
                                              : 16'($urandom);
          push_event(close_event(missed));
          sent += n + 2;
          if ($urandom_range(0, 9) < 4) begin
            push_event(finish_event());
            sent++;
          end
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) push_event(noise_event());
          sent += n;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_scan_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_behaviour();
    test_directed_windows();
    test_clear_margin();
    test_random_scan();
    wait_idle();
    // Let any stray result show up before the verdict
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** bitrate_candidate_scorer_unit: PASSED **");
    end else begin
      $display("** bitrate_candidate_scorer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** bitrate_candidate_scorer_unit: FAILED **");
    $finish;
  end

endmodule
